// ===== rtl/core/dmhp_pkg.sv =====
package dmhp_pkg;

   // fixed field widths
   localparam int GAIN_W  = 18;
   localparam int LIMIT_W = 12;
   localparam int ANGLE_W = 9;
   localparam int SPEED_W = 10;
   localparam int ERR_W   = 10;
   localparam int INTEG_W = 13;
   localparam int DIFF_W  = 11;
   localparam int MOTOR_W = 12;
   localparam int PID_W   = 11;
   localparam int CSR_AW  = 2;

   // product widths: unsigned gain (with a sign bit added) times signed operand
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;

   localparam int FRAC_BITS_DEFAULT = 16;

   // register indexes of the configuration port
   typedef enum logic [CSR_AW-1:0] {
      CSR_GAIN_P    = 2'd0,
      CSR_GAIN_I    = 2'd1,
      CSR_GAIN_D    = 2'd2,
      CSR_INT_LIMIT = 2'd3
   } csr_index_type;

   // stage 1 -> stage 2
   typedef struct packed {
      logic                      turn;
      logic [SPEED_W-1:0]        speed;
      logic signed [ERR_W-1:0]   err;
      logic signed [INTEG_W-1:0] integ;
      logic signed [DIFF_W-1:0]  diff;
   } err_stage_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic                       turn;
      logic [SPEED_W-1:0]         speed;
      logic signed [PROD_P_W-1:0] prod_p;
      logic signed [PROD_I_W-1:0] prod_i;
      logic signed [PROD_D_W-1:0] prod_d;
   } prod_stage_type;

   // gain settings handed to the multiplier stage
   typedef struct packed {
      logic [GAIN_W-1:0] p;
      logic [GAIN_W-1:0] i;
      logic [GAIN_W-1:0] d;
   } gains_type;

endpackage

// ===== rtl/core/dual_mode_heading_pid.sv =====
// Heading PID for a two-motor vehicle, one control step per beat.
// req channel: tuser carries the mode (0 line tracking, 1 turn in place);
//   tdata carries angle_in, the measured yaw and base_speed.
// rsp channel: tdata carries the left and right motor commands.
// csr port: csr_we writes csr_wdata to register csr_addr at the clock edge
//   (0 gain_p, 1 gain_i, 2 gain_d, 3 integral_limit); write only while idle.
// Pipeline: three register stages (error/integral stage, multiplier stage,
//   sum/clamp/mix stage with the result register), which each beat passes
//   in that order. Throughput: one beat per cycle while rsp_tready is high;
//   the three products come from three parallel multipliers.
// The integral and last error advance in the first stage as each beat is
//   taken, so consecutive steps need no wait.
// When the receiver stalls, each stage holds its data and the pipeline keeps
//   filling; req_tready drops only when all three stages are full.
// Reset (synchronous, active high) empties the pipeline, clears the integral
//   and last error, and returns the gains and the limit to their defaults
//   (0.8, 0.01, 0.1 in fixed point, limit 1000).
module dual_mode_heading_pid #(
   parameter int FRAC_BITS = dmhp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,  // angle_in[8:0], yaw_meas[17:9],
                                                    // base_speed[27:18], zero fill
   input  logic [0:0]                   req_tuser,  // op
   // response
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,  // motor_a[11:0], motor_b[23:12]
   // configuration
   input  logic                         csr_we,
   input  logic [dmhp_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [dmhp_pkg::GAIN_W-1:0]  csr_wdata
);
   import dmhp_pkg::*;

   localparam logic [GAIN_W-1:0] GainPRst =
      GAIN_W'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [GAIN_W-1:0] GainIRst =
      GAIN_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [GAIN_W-1:0] GainDRst =
      GAIN_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [LIMIT_W-1:0] IntLimitRst = LIMIT_W'(1000);

   gains_type          gains_ff, gains_in;
   logic [LIMIT_W-1:0] int_limit_ff, int_limit_in;

   logic               s1_valid, s1_ready, s2_valid, s2_ready;
   err_stage_type      s1_data;
   prod_stage_type     s2_data;
   logic [MOTOR_W-1:0] motor_a, motor_b;

   // configuration registers
   always_comb begin
      gains_in     = gains_ff;
      int_limit_in = int_limit_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_GAIN_P:    gains_in.p   = csr_wdata;
            CSR_GAIN_I:    gains_in.i   = csr_wdata;
            CSR_GAIN_D:    gains_in.d   = csr_wdata;
            CSR_INT_LIMIT: int_limit_in = csr_wdata[LIMIT_W-1:0];
            default:       int_limit_in = int_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.p   <= GainPRst;
         gains_ff.i   <= GainIRst;
         gains_ff.d   <= GainDRst;
         int_limit_ff <= IntLimitRst;
      end else begin
         gains_ff     <= gains_in;
         int_limit_ff <= int_limit_in;
      end
   end

   dmhp_err u_err (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_turn   (req_tuser[0]),
      .in_angle  (req_tdata[8:0]),
      .in_yaw    (req_tdata[17:9]),
      .in_speed  (req_tdata[27:18]),
      .int_limit (int_limit_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   dmhp_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   dmhp_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .in_data     (s2_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_motor_a (motor_a),
      .out_motor_b (motor_b)
   );

   assign rsp_tdata = {motor_b, motor_a};

endmodule

// ===== rtl/core/dmhp_err.sv =====
// Stage 1: error forming, integral saturation and derivative difference.
// Owns the controller state, which advances on every accepted beat.
module dmhp_err (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_turn,
   input  logic [dmhp_pkg::ANGLE_W-1:0]  in_angle,
   input  logic [dmhp_pkg::ANGLE_W-1:0]  in_yaw,
   input  logic [dmhp_pkg::SPEED_W-1:0]  in_speed,
   input  logic [dmhp_pkg::LIMIT_W-1:0]  int_limit,
   output logic                          out_valid,
   input  logic                          out_ready,
   output dmhp_pkg::err_stage_type       out_data
);
   import dmhp_pkg::*;

   logic                      valid_ff, valid_in;
   err_stage_type             data_ff, data_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;

   logic                      accept;
   logic signed [ERR_W-1:0]   ang_ext, yaw_ext, err;
   logic signed [INTEG_W:0]   integ_sum, lim_pos, lim_neg;
   logic signed [INTEG_W-1:0] integ_sat;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // error: negated deviation when tracking, target minus yaw when turning
   always_comb begin
      ang_ext = {in_angle[ANGLE_W-1], in_angle};
      yaw_ext = {in_yaw[ANGLE_W-1], in_yaw};
      if (in_turn) begin
         err = ang_ext - yaw_ext;
      end else begin
         err = -ang_ext;
      end
   end

   // integral with symmetric saturation
   always_comb begin
      integ_sum = {integ_ff[INTEG_W-1], integ_ff} + (INTEG_W+1)'(err);
      lim_pos   = signed'({{(INTEG_W+1-LIMIT_W){1'b0}}, int_limit});
      lim_neg   = -lim_pos;
      if (integ_sum > lim_pos) begin
         integ_sat = lim_pos[INTEG_W-1:0];
      end else if (integ_sum < lim_neg) begin
         integ_sat = lim_neg[INTEG_W-1:0];
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
   end

   always_comb begin
      integ_in    = integ_ff;
      last_err_in = last_err_ff;
      valid_in    = valid_ff;
      data_in     = data_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         integ_in      = integ_sat;
         last_err_in   = err;
         valid_in      = 1'b1;
         data_in.turn  = in_turn;
         data_in.speed = in_speed;
         data_in.err   = err;
         data_in.integ = integ_sat;
         data_in.diff  = DIFF_W'(err) - DIFF_W'(last_err_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/dmhp_mult.sv =====
// Stage 2: the three gain products, registered.
module dmhp_mult (
   input  logic                      clock,
   input  logic                      reset,
   input  dmhp_pkg::gains_type       gains,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  dmhp_pkg::err_stage_type   in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dmhp_pkg::prod_stage_type  out_data
);
   import dmhp_pkg::*;

   logic           valid_ff, valid_in;
   prod_stage_type data_ff, data_in;
   logic           accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in       = 1'b1;
         data_in.turn   = in_data.turn;
         data_in.speed  = in_data.speed;
         data_in.prod_p = PROD_P_W'(signed'({1'b0, gains.p})) * PROD_P_W'(in_data.err);
         data_in.prod_i = PROD_I_W'(signed'({1'b0, gains.i})) * PROD_I_W'(in_data.integ);
         data_in.prod_d = PROD_D_W'(signed'({1'b0, gains.d})) * PROD_D_W'(in_data.diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/dmhp_out.sv =====
// Stage 3: PID sum, clamp to +/- base speed, truncation toward zero,
// motor mixing, and the result register.
module dmhp_out #(
   parameter int FRAC_BITS = dmhp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dmhp_pkg::prod_stage_type      in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [dmhp_pkg::MOTOR_W-1:0]  out_motor_a,
   output logic [dmhp_pkg::MOTOR_W-1:0]  out_motor_b
);
   import dmhp_pkg::*;

   // room for the sum of products and for base_speed << FRAC_BITS
   localparam int AccW = (FRAC_BITS + SPEED_W + 2 > 33) ? FRAC_BITS + SPEED_W + 2 : 33;

   logic                     valid_ff, valid_in;
   logic [MOTOR_W-1:0]       motor_a_ff, motor_a_in, motor_b_ff, motor_b_in;
   logic                     accept;

   logic signed [AccW-1:0]   acc, bound, bound_neg;
   logic [AccW-1:0]          mag, quot;
   logic signed [PID_W-1:0]  pid;
   logic signed [MOTOR_W-1:0] pid_ext, speed_ext;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // PID sum and clamp bounds
   always_comb begin
      acc = AccW'(in_data.prod_p) + AccW'(in_data.prod_i) + AccW'(in_data.prod_d);
      bound     = signed'(AccW'(in_data.speed) << FRAC_BITS);
      bound_neg = -bound;
      mag       = acc[AccW-1] ? unsigned'(-acc) : unsigned'(acc);
      quot      = mag >> FRAC_BITS;
   end

   // clamp, else drop the fraction toward zero
   always_comb begin
      if (acc > bound) begin
         pid = signed'({1'b0, in_data.speed});
      end else if (acc < bound_neg) begin
         pid = -signed'({1'b0, in_data.speed});
      end else if (acc[AccW-1]) begin
         pid = -signed'(quot[PID_W-1:0]);
      end else begin
         pid = signed'(quot[PID_W-1:0]);
      end
   end

   // motor mixing
   always_comb begin
      pid_ext   = MOTOR_W'(pid);
      speed_ext = signed'(MOTOR_W'(in_data.speed));
      valid_in   = valid_ff;
      motor_a_in = motor_a_ff;
      motor_b_in = motor_b_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         if (in_data.turn) begin
            motor_a_in = -pid_ext;
            motor_b_in = pid_ext;
         end else begin
            motor_a_in = speed_ext - pid_ext;
            motor_b_in = speed_ext + pid_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      motor_a_ff <= motor_a_in;
      motor_b_ff <= motor_b_in;
   end

   assign out_valid   = valid_ff;
   assign out_motor_a = motor_a_ff;
   assign out_motor_b = motor_b_ff;

endmodule
